FILE: src/hbss_pkg.sv
// Shared types and operation codes for the hash bucket slot store.
package hbss_pkg;

  localparam int DefSlots     = 32;
  localparam int DefKeyBits   = 64;
  localparam int DefValueBits = 64;

  localparam int ModeBits = 3;
  localparam int KeyWidth = 64;
  localparam int ValWidth = 64;
  localparam int CntWidth = 6;

  localparam logic [ModeBits-1:0] MODE_LOOKUP = 3'd0;
  localparam logic [ModeBits-1:0] MODE_INSERT = 3'd1;
  localparam logic [ModeBits-1:0] MODE_REMOVE = 3'd2;
  localparam logic [ModeBits-1:0] MODE_DUP    = 3'd3;
  localparam logic [ModeBits-1:0] MODE_CLEAR  = 3'd4;

  // Control part of the request token walking down the cell row.
  typedef struct packed {
    logic                valid;
    logic [ModeBits-1:0] mode;
    logic                stop;   // passed a never-occupied slot
    logic                done;   // insert/remove/dup already resolved
    logic                ok;
  } tok_ctl_t;

  // What one cell reports to the top level while it handles the token.
  typedef struct packed {
    logic hit;   // lookup match
    logic inc;   // a slot became readable
    logic dec;   // a slot lost its readable bit
  } cell_rpt_t;

endpackage

FILE: src/hbss_cell.sv
// One slot of the bucket: key/value storage, occupied and readable bits, token stage.
module hbss_cell #(
  parameter int KEY_BITS   = hbss_pkg::DefKeyBits,
  parameter int VALUE_BITS = hbss_pkg::DefValueBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  hbss_pkg::tok_ctl_t       in_ctl,
  input  logic [KEY_BITS-1:0]      in_key,
  input  logic [VALUE_BITS-1:0]    in_val,
  output hbss_pkg::tok_ctl_t       out_ctl,
  output logic [KEY_BITS-1:0]      out_key,
  output logic [VALUE_BITS-1:0]    out_val,
  output hbss_pkg::cell_rpt_t      rpt,
  output logic [VALUE_BITS-1:0]    hit_value
);
  import hbss_pkg::*;

  tok_ctl_t              ctl_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [KEY_BITS-1:0]   slot_key;
  logic [VALUE_BITS-1:0] slot_val;
  logic                  occ;
  logic                  rd;
  logic                  occ_next;
  logic                  rd_next;
  logic                  wr;
  logic                  key_eq;
  logic                  pair_eq;

  assign key_eq  = (slot_key == key_q);
  assign pair_eq = key_eq && (slot_val == val_q);
  assign out_key = key_q;
  assign out_val = val_q;

  always_comb begin
    out_ctl   = ctl_q;
    rpt       = '0;
    hit_value = '0;
    occ_next  = occ;
    rd_next   = rd;
    wr        = 1'b0;
    if (ctl_q.valid) begin
      case (ctl_q.mode)
        MODE_LOOKUP: begin
          if (!ctl_q.stop) begin
            if (!occ) begin
              out_ctl.stop = 1'b1;
            end else if (rd && key_eq) begin
              rpt.hit   = 1'b1;
              hit_value = slot_val;
            end
          end
        end
        MODE_INSERT: begin
          if (!ctl_q.done && !rd) begin
            wr           = 1'b1;
            occ_next     = 1'b1;
            rd_next      = 1'b1;
            rpt.inc      = 1'b1;
            out_ctl.done = 1'b1;
            out_ctl.ok   = 1'b1;
          end
        end
        MODE_REMOVE, MODE_DUP: begin
          if (!ctl_q.stop && !ctl_q.done) begin
            if (!occ) begin
              out_ctl.stop = 1'b1;
            end else if (rd && pair_eq) begin
              out_ctl.done = 1'b1;
              out_ctl.ok   = 1'b1;
              if (ctl_q.mode == MODE_REMOVE) begin
                rd_next = 1'b0;
                rpt.dec = 1'b1;
              end
            end
          end
        end
        MODE_CLEAR: begin
          occ_next   = 1'b0;
          rd_next    = 1'b0;
          out_ctl.ok = 1'b1;
        end
        default: begin
          out_ctl.ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
      occ   <= 1'b0;
      rd    <= 1'b0;
    end else if (adv) begin
      ctl_q <= in_ctl;
      occ   <= occ_next;
      rd    <= rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_q <= in_key;
      val_q <= in_val;
      if (wr) begin
        slot_key <= key_q;
        slot_val <= val_q;
      end
    end
  end

endmodule

FILE: src/hash_bucket_slot_store.sv
// Top level of the hash bucket slot store: request entry, cell row, result output.
//
// A bucket of SLOTS key/value slots with tombstones. Each request (lookup, insert,
// remove, duplicate check, clear) walks a row of SLOTS cells, one slot per cycle
// while the output side does not stall (the row only advances while the output
// register is free). One request is handled at a time; the next is taken the
// cycle after the final result has been loaded into the output register. A
// lookup gives one result per matching slot in slot order, tlast on the final
// one; with no match it gives one result with ok low. Every other request gives
// exactly one result. Each result carries the readable slot count after the
// request and the full and empty flags.
module hash_bucket_slot_store #(
  parameter int SLOTS      = hbss_pkg::DefSlots,
  parameter int KEY_BITS   = hbss_pkg::DefKeyBits,
  parameter int VALUE_BITS = hbss_pkg::DefValueBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // mode[2:0], key[66:3], value[130:67], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // ok[0], found_value[64:1], live_count[70:65],
                                  // full_res[71], empty_res[72], zero pad
  output logic         m_tlast
);
  import hbss_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  tok_ctl_t              link_ctl [SLOTS+1];
  logic [KEY_BITS-1:0]   link_key [SLOTS+1];
  logic [VALUE_BITS-1:0] link_val [SLOTS+1];
  cell_rpt_t             rpt      [SLOTS];
  logic [VALUE_BITS-1:0] hval     [SLOTS];

  tok_ctl_t              inj_ctl;
  logic [KEY_BITS-1:0]   inj_key;
  logic [VALUE_BITS-1:0] inj_val;
  tok_ctl_t              tail_q;
  logic                  busy;
  logic                  adv;
  logic [CW-1:0]         count;
  logic                  pend_valid;
  logic [VALUE_BITS-1:0] pend_val;

  logic                  any_hit;
  logic                  any_inc;
  logic                  any_dec;
  logic [VALUE_BITS-1:0] hit_or;

  logic                  o_ok;
  logic [ValWidth-1:0]   o_val;
  logic [CntWidth-1:0]   o_lc;
  logic                  o_full;
  logic                  o_empty;

  logic                  emit;
  logic                  e_ok;
  logic [ValWidth-1:0]   e_val;
  logic                  e_last;
  logic [CW-1:0]         e_cnt;
  logic [7:0]            e_cnt_ext;
  logic                  fin_clear;

  assign s_tready = !busy;
  assign adv      = !m_tvalid || m_tready;

  assign link_ctl[0] = inj_ctl;
  assign link_key[0] = inj_key;
  assign link_val[0] = inj_val;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    hbss_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_ctl    (link_ctl[i]),
      .in_key    (link_key[i]),
      .in_val    (link_val[i]),
      .out_ctl   (link_ctl[i+1]),
      .out_key   (link_key[i+1]),
      .out_val   (link_val[i+1]),
      .rpt       (rpt[i]),
      .hit_value (hval[i])
    );
  end

  // Only one token is in flight, so at most one cell reports at a time.
  always_comb begin
    any_hit = 1'b0;
    any_inc = 1'b0;
    any_dec = 1'b0;
    hit_or  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_hit = any_hit | rpt[i].hit;
      any_inc = any_inc | rpt[i].inc;
      any_dec = any_dec | rpt[i].dec;
      hit_or  = hit_or | hval[i];
    end
  end

  // Lookup matches are held back by one so the final one can carry tlast.
  always_comb begin
    fin_clear = tail_q.valid && (tail_q.mode == MODE_CLEAR);
    emit      = 1'b0;
    e_ok      = 1'b0;
    e_val     = '0;
    e_last    = 1'b0;
    e_cnt     = fin_clear ? '0 : count;
    if (tail_q.valid) begin
      emit   = 1'b1;
      e_last = 1'b1;
      if (tail_q.mode == MODE_LOOKUP) begin
        e_ok  = pend_valid;
        e_val = pend_valid ? ValWidth'(pend_val) : '0;
      end else begin
        e_ok = tail_q.ok;
      end
    end else if (any_hit && pend_valid) begin
      emit  = 1'b1;
      e_ok  = 1'b1;
      e_val = ValWidth'(pend_val);
    end
    e_cnt_ext = 8'(e_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      inj_ctl    <= '0;
      tail_q     <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        busy          <= 1'b1;
        inj_ctl.valid <= 1'b1;
        inj_ctl.mode  <= s_tdata[2:0];
        inj_ctl.stop  <= 1'b0;
        inj_ctl.done  <= 1'b0;
        inj_ctl.ok    <= 1'b0;
      end else if (adv) begin
        inj_ctl.valid <= 1'b0;
      end
      if (adv) begin
        tail_q <= link_ctl[SLOTS];
        if (fin_clear) begin
          count <= '0;
        end else if (any_inc) begin
          count <= count + CW'(1);
        end else if (any_dec) begin
          count <= count - CW'(1);
        end
        if (tail_q.valid) begin
          pend_valid <= 1'b0;
          busy       <= 1'b0;
        end else if (any_hit) begin
          pend_valid <= 1'b1;
        end
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      inj_key <= s_tdata[3 +: KEY_BITS];
      inj_val <= s_tdata[67 +: VALUE_BITS];
    end
    if (adv) begin
      if (any_hit) begin
        pend_val <= hit_or;
      end
      if (emit) begin
        o_ok    <= e_ok;
        o_val   <= e_val;
        m_tlast <= e_last;
        o_lc    <= (e_cnt_ext > 8'd63) ? 6'd63 : e_cnt_ext[5:0];
        o_full  <= (e_cnt == CW'(SLOTS));
        o_empty <= (e_cnt == '0);
      end
    end
  end

  assign m_tdata = {7'd0, o_empty, o_full, o_lc, o_val, o_ok};

endmodule
